[rtl/sha512_pkg.sv]
// Package: SHA-512 constants, round constant table and round functions.
package sha512_pkg;

  localparam int unsigned LenBits = 64;
  localparam int unsigned Rounds = 80;
  localparam int unsigned BlockWords = 16;
  localparam logic [3:0] LengthSlot = 4'd14;

  localparam logic [63:0] InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  typedef logic [63:0] word_t;

  // handshake between sequencer and compression unit
  typedef struct packed {
    logic start;
    logic busy;
  } core_ctl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

[rtl/sha512_core.sv]
// Compression unit: one SHA-512 round per cycle over a rolling 16-word schedule window.
module sha512_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                init_i,
  input  logic                wr_i,
  input  logic [3:0]          wr_idx_i,
  input  sha512_pkg::word_t   wr_word_i,
  input  logic                start_i,
  output sha512_pkg::core_ctl_t ctl_o,
  input  logic [2:0]          rd_idx_i,
  output sha512_pkg::word_t   rd_word_o
);

  typedef enum logic [2:0] {
    CIdle = 3'b001,
    CRound = 3'b010,
    CAdd = 3'b100
  } core_state_e;

  core_state_e state_q, state_d;
  logic [6:0] t_q;
  sha512_pkg::word_t h_q [8];
  sha512_pkg::word_t v_q [8];
  sha512_pkg::word_t w_q [16];
  sha512_pkg::word_t w_cur, t1, t2;
  logic [3:0] ti;

  assign ti = t_q[3:0];

  always_comb begin
    if (t_q < 7'(sha512_pkg::BlockWords)) begin
      w_cur = w_q[ti];
    end else begin
      w_cur = sha512_pkg::small_sigma1(w_q[ti - 4'd2]) + w_q[ti - 4'd7]
            + sha512_pkg::small_sigma0(w_q[ti - 4'd15]) + w_q[ti];
    end
    t1 = v_q[7] + sha512_pkg::big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha512_pkg::RoundK[t_q] + w_cur;
    t2 = sha512_pkg::big_sigma0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CIdle:   if (start_i) state_d = CRound;
      CRound:  if (t_q == 7'(sha512_pkg::Rounds - 1)) state_d = CAdd;
      CAdd:    state_d = CIdle;
      default: state_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      t_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::InitHash[i];
    end else begin
      state_q <= state_d;
      if (state_q == CIdle) begin
        t_q <= '0;
        if (init_i) begin
          for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::InitHash[i];
        end
      end else if (state_q == CRound) begin
        t_q <= t_q + 7'd1;
      end else if (state_q == CAdd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CIdle) begin
      if (wr_i) w_q[wr_idx_i] <= wr_word_i;
      if (start_i) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end else if (state_q == CRound) begin
      w_q[ti] <= w_cur;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy = (state_q != CIdle);
  assign rd_word_o = h_q[rd_idx_i];

endmodule

[rtl/sha512_hash_engine_unit.sv]
// Top level: SHA-512 engine with word intake, hardware padding and digest output.
//   channel | dir | tdata                         | tuser
//   s_axis  | in  | message_word[63:0], valid_bytes[67:64] | -      (tlast = last_word)
//   m_axis  | out | digest_word[63:0], digest_index[66:64] | -      (tlast = digest_last)
// A word that does not close a block is written into the schedule window; the 16th
// word of a block starts the rounds and the add step in the core. The final word adds
// padding words, one per cycle while the core is not busy, a compression per 16, then
// eight output words. Reset restores the initial hash and clears the counters.
// A stalled m_axis holds the current digest word; s_axis is not ready meanwhile.
module sha512_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // message_word[63:0], valid_bytes[67:64], zeros
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // digest_word[63:0], digest_index[66:64], zeros
  output logic        m_axis_tlast
);

  typedef enum logic [4:0] {
    SIn   = 5'b00001,
    SPad  = 5'b00010,
    SWait = 5'b00100,
    SOut  = 5'b01000,
    SInit = 5'b10000
  } seq_state_e;

  seq_state_e state_q, state_d;
  logic [3:0] nwords_q, nwords_d;
  logic [sha512_pkg::LenBits-1:0] count_q, count_d;
  logic [2:0] oidx_q, oidx_d;
  logic pad_one_q, pad_one_d;      // 0x80 word still owed (full final word)
  logic after_wait_pad_q, after_wait_pad_d;
  logic acc;
  logic wr;
  sha512_pkg::word_t wr_word;
  logic start;
  logic init;
  sha512_pkg::core_ctl_t ctl;
  sha512_pkg::word_t rd_word;
  logic [3:0] nb;
  logic [63:0] keep;
  logic [127:0] bitlen;
  sha512_pkg::word_t pad_word;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == SIn) && !ctl.busy;
  assign nb = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
  assign keep = (nb == 4'd0) ? 64'd0 : ~(64'd0) << (7'd64 - {nb, 3'd0});
  assign bitlen = 128'({count_q, 3'd0});

  always_comb begin
    if (pad_one_q) pad_word = 64'h8000000000000000;
    else if (nwords_q == sha512_pkg::LengthSlot) pad_word = bitlen[127:64];
    else if (nwords_q == 4'd15 && !after_wait_pad_q) pad_word = bitlen[63:0];
    else pad_word = '0;
  end

  always_comb begin
    state_d = state_q;
    nwords_d = nwords_q;
    count_d = count_q;
    oidx_d = oidx_q;
    pad_one_d = pad_one_q;
    after_wait_pad_d = after_wait_pad_q;
    wr = 1'b0;
    wr_word = s_axis_tdata[63:0];
    start = 1'b0;
    init = 1'b0;
    case (state_q)
      SIn: begin
        if (acc) begin
          wr = 1'b1;
          nwords_d = nwords_q + 4'd1;
          start = (nwords_q == 4'd15);
          if (!s_axis_tlast) begin
            count_d = count_q + sha512_pkg::LenBits'(8);
          end else begin
            count_d = count_q + sha512_pkg::LenBits'(nb);
            if (nb < 4'd8) begin
              wr_word = (s_axis_tdata[63:0] & keep) | (64'h80 << (7'd56 - {nb, 3'd0}));
            end else begin
              pad_one_d = 1'b1;
            end
            // a final partial word in slot 14 leaves the length for a new block
            after_wait_pad_d = (nwords_q == sha512_pkg::LengthSlot) && (nb < 4'd8);
            state_d = SPad;
          end
        end
      end
      SPad: begin
        if (!ctl.busy) begin
          // a block holding more than 14 words after the pad bit is closed with zeros
          wr = 1'b1;
          wr_word = pad_word;
          if (!pad_one_q && nwords_q < sha512_pkg::LengthSlot && !after_wait_pad_q) begin
            wr_word = '0;
          end
          if (!pad_one_q && after_wait_pad_q && nwords_q != 4'd15) wr_word = '0;
          if (!pad_one_q && after_wait_pad_q && nwords_q == 4'd15) wr_word = '0;
          nwords_d = nwords_q + 4'd1;
          pad_one_d = 1'b0;
          if (nwords_q == 4'd15) begin
            start = 1'b1;
            if (pad_one_q || after_wait_pad_q || nwords_q != 4'd15) begin
              after_wait_pad_d = 1'b0;
            end
            state_d = (pad_one_q || after_wait_pad_q) ? SPad : SWait;
            after_wait_pad_d = 1'b0;
          end
          if (pad_one_q && nwords_q == sha512_pkg::LengthSlot) after_wait_pad_d = 1'b1;
          if (pad_one_q && nwords_q == 4'd15) after_wait_pad_d = 1'b0;
          if (nwords_q == 4'd15 && pad_one_q) state_d = SPad;
        end
      end
      SWait: begin
        if (!ctl.busy && !ctl.start) begin
          state_d = SOut;
          oidx_d = '0;
        end
      end
      SOut: begin
        if (m_axis_tready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) state_d = SInit;
        end
      end
      SInit: begin
        init = 1'b1;
        nwords_d = '0;
        count_d = '0;
        pad_one_d = 1'b0;
        after_wait_pad_d = 1'b0;
        state_d = SIn;
      end
      default: state_d = SIn;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIn;
      nwords_q <= '0;
      count_q <= '0;
      oidx_q <= '0;
      pad_one_q <= 1'b0;
      after_wait_pad_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nwords_q <= nwords_d;
      count_q <= count_d;
      oidx_q <= oidx_d;
      pad_one_q <= pad_one_d;
      after_wait_pad_q <= after_wait_pad_d;
    end
  end

  sha512_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .init_i    (init),
    .wr_i      (wr),
    .wr_idx_i  (nwords_q),
    .wr_word_i (wr_word),
    .start_i   (start),
    .ctl_o     (ctl),
    .rd_idx_i  (oidx_q),
    .rd_word_o (rd_word)
  );

  assign m_axis_tvalid = (state_q == SOut);
  assign m_axis_tdata = {5'd0, oidx_q, rd_word};
  assign m_axis_tlast = (oidx_q == 3'd7);

  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.busy |-> !s_axis_tready) else $error("input taken during compression");
  a_out_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !ctl.busy) else $error("digest shown during compression");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (state_q == SInit))
    else $error("no restart after digest");

endmodule
